// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/swm_pkg.sv
package swm_pkg;

   localparam int MAX_WINDOW   = 16;
   localparam int SAMPLE_W     = 32;
   localparam int WIN_W        = 5;
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int WINDOW_RESET = 3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [WIN_W-1:0]    win_type;
   typedef logic        [IDX_W-1:0]    idx_type;

   // Broadcast from the control logic to every cell
   typedef struct packed {
      logic       shift;   // an item is taken in this cycle
      sample_type sample;  // the new sample
   } cell_ctl_type;

endpackage

// File: design/swm_cell.sv
// One cell of the prefix-max chain. Cell k holds the max of the newest k+1
// samples. When a sample comes in, it becomes max(new sample, neighbor's
// old value), since the neighbor covered the newest k samples before.
module swm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::cell_ctl_type ctl,
   input  swm_pkg::sample_type   nbr_max,
   output swm_pkg::sample_type   max_ff,
   output swm_pkg::sample_type   max_in
);
   import swm_pkg::*;

   // signed compare against the broadcast sample
   always_comb begin
      max_in = (ctl.sample > nbr_max) ? ctl.sample : nbr_max;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (ctl.shift) begin
         max_ff <= max_in;
      end
   end

endmodule

// File: design/sliding_window_max_top.sv
// Sliding window maximum over a stream of signed 32-bit samples.
// Input channel req_*: one sample per item in req_tdata, req_tuser marks the
// first sample of a sequence (clears the fill count), req_tlast marks the
// last sample and is copied to the result's rsp_tlast.
// Result channel rsp_*: rsp_tdata is the max of the newest window_length
// samples. An item gives a result only once window_length samples have come
// in since the last sequence start; earlier items give none.
// csr_wr_en/csr_wr_data write window_length (0 acts as 1, above 16 as 16).
// Write it only while no result is pending.
// A result is registered and shows on rsp_* in the cycle after its item is accepted.
// Throughput: one item per cycle, set by a chain of 16 cells that each
// update with one compare per item, plus one output register.
// The output register accepts a new item in the same cycle the held result
// is taken; when the receiver stalls with a result held, req_tready drops.
// Reset clears the fill count, the cells and the output valid, and sets
// window_length to 3.
module sliding_window_max_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // window_length
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] sample
   input  logic        req_tuser,     // [0] sequence_start
   input  logic        req_tlast,     // last_sample
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [31:0] window_max
   output logic        rsp_tlast      // sequence_end
);
   import swm_pkg::*;

   win_type      win_ff;
   win_type      win_eff;
   win_type      fill_ff;
   win_type      fill_in;
   win_type      fill_base;
   idx_type      sel;
   logic         accept;
   logic         hit;
   logic         rsp_valid_ff;
   sample_type   rsp_data_ff;
   logic         rsp_last_ff;
   cell_ctl_type ctl;
   sample_type   cell_max_ff [MAX_WINDOW];
   sample_type   cell_max_in [MAX_WINDOW];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign ctl.shift  = accept;
   assign ctl.sample = sample_type'(req_tdata);

   // chain of cells; cell 0 compares the sample with itself
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         swm_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .nbr_max (ctl.sample),
            .max_ff  (cell_max_ff[k]),
            .max_in  (cell_max_in[k])
         );
      end else begin : g_body
         swm_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .nbr_max (cell_max_ff[k-1]),
            .max_ff  (cell_max_ff[k]),
            .max_in  (cell_max_in[k])
         );
      end
   end

   // effective window: clamp to 1..MAX_WINDOW
   always_comb begin
      if (win_ff == '0) begin
         win_eff = win_type'(1);
      end else if (win_ff > win_type'(MAX_WINDOW)) begin
         win_eff = win_type'(MAX_WINDOW);
      end else begin
         win_eff = win_ff;
      end
      sel = idx_type'(win_eff - win_type'(1));
   end

   // fill count after this item, saturating
   always_comb begin
      fill_base = req_tuser ? '0 : fill_ff;
      fill_in   = (fill_base < win_type'(MAX_WINDOW)) ? fill_base + win_type'(1)
                                                       : fill_base;
      hit       = (fill_in >= win_eff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= win_type'(WINDOW_RESET);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         if (accept) begin
            fill_ff      <= fill_in;
            rsp_valid_ff <= hit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && hit) begin
         rsp_data_ff <= cell_max_in[sel];
         rsp_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/swm_checker.sv
`include "assert_macros.svh"

// Port-level checks for the sliding window max block.
module swm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic        rsp_stall;
   logic        req_take;
   logic [32:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_take  = req_tvalid && req_tready;
   assign rsp_word  = {rsp_tlast, rsp_tdata};

   // a stalled result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word), "held result changed")

   // input side only waits on a stalled, held result
   `ASSERT_SAME(a_ready, clock, reset, !req_tready, rsp_stall, "input stalled without cause")

   // a new result only follows an accepted item
   `ASSERT_SAME(a_rsp_src, clock, reset, $rose(rsp_tvalid), $past(req_take), "result without item")

   // no result right out of reset
   `ASSERT_SAME(a_reset_idle, clock, reset, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

bind sliding_window_max_top swm_checker u_swm_checker (.*);

// File: bench/tb.sv
module tb;
   import swm_pkg::*;

   // One expected result: window maximum and the copied end flag
   typedef struct {
      sample_type peak;
      bit         seq_end;
   } peak_rec_type;

   // Tracks window contents, fill count and length, and the maxima still owed
   class window_max_board_type;
      sample_type   history[MAX_WINDOW];   // [0] is the newest sample
      int unsigned  fill;
      win_type      win_len;
      peak_rec_type owed_peaks[$];
      int           errors;

      function new();
         foreach (history[i]) history[i] = '0;
         fill    = 0;
         win_len = win_type'(WINDOW_RESET);
         errors  = 0;
      endfunction

      function void set_window(win_type v);
         win_len = v;
      endfunction

      function int unsigned span();
         if (win_len == 0) return 1;
         if (win_len > MAX_WINDOW) return MAX_WINDOW;
         return win_len;
      endfunction

      function int pending();
         return owed_peaks.size();
      endfunction

      // Accepted input item: shift it in, owe a maximum once the window is full
      function void note_sample(sample_type s, bit start, bit last);
         peak_rec_type rec;
         int unsigned w;
         w = span();
         if (start) fill = 0;
         for (int i = MAX_WINDOW - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = s;
         if (fill < MAX_WINDOW) fill++;
         if (fill < w) return;
         rec.peak = history[0];
         for (int i = 1; i < w; i++)
            if ($signed(history[i]) > $signed(rec.peak)) rec.peak = history[i];
         rec.seq_end = last;
         owed_peaks = {owed_peaks, rec};
      endfunction

      // Accepted result item: compare with the oldest owed maximum
      function void check_result(sample_type got, bit got_end);
         peak_rec_type rec;
         if (owed_peaks.size() == 0) begin
            $display("%0t: unexpected result, window_max %h tlast %b", $time, got, got_end);
            errors++;
            return;
         end
         rec = owed_peaks.pop_front();
         if (got !== rec.peak) begin
            $display("%0t: window_max expected %h, got %h", $time, rec.peak, got);
            errors++;
         end
         if (got_end !== rec.seq_end) begin
            $display("%0t: sequence_end expected %b, got %b", $time, rec.seq_end, got_end);
            errors++;
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   window_max_board_type board = new();
   bit calm = 1'b0;      // no gaps or stalls while set
   int samples_sent = 0;

   sliding_window_max_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   // Handshake monitor: results first, then new items, then register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) board.note_sample(req_tdata, req_tuser, req_tlast);
         if (csr_wr_en) board.set_window(csr_wr_data);
      end
   end

   // Mostly short pauses, a few long ones
   function automatic int pick_pause(int longest);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(4, longest);
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return sample_type'(int'($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // Result side backpressure
   initial begin
      int run;
      int stall;
      wait (!reset);
      forever begin
         run   = $urandom_range(1, 8);
         stall = pick_pause(20);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Present one item and hold it until taken; valid stays high afterwards
   task automatic push_sample(sample_type s, bit start, bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= start;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic sender_gap();
      int g;
      g = pick_pause(25);
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send(sample_type s, bit start, bit last);
      push_sample(s, start, last);
      sender_gap();
   endtask

   // Hold the sender until every owed result is out and the block is quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_window(win_type v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random phase: a window setting followed by a few sequences
   task automatic run_phase();
      win_type     v;
      int unsigned w;
      int          nseq;
      int          len;
      int          kind;
      bit          start_first;
      win_type     extremes[7] = '{5'd0, 5'd1, 5'd2, 5'd15, 5'd16, 5'd17, 5'd31};
      if ($urandom_range(0, 9) < 4) v = extremes[$urandom_range(0, 6)];
      else v = win_type'($urandom_range(0, 31));
      load_window(v);
      calm = ($urandom_range(0, 3) == 0);
      w = board.span();
      nseq = $urandom_range(1, 4);
      for (int q = 0; q < nseq; q++) begin
         kind = $urandom_range(0, 99);
         start_first = ($urandom_range(0, 9) != 0);
         if (kind < 70) begin
            len = w + $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
               send(rand_sample(), (i == 0) && start_first, i == len - 1);
         end else if (kind < 85) begin
            // no longer than the window, so a started sequence gives at most one result
            len = $urandom_range(1, w);
            for (int i = 0; i < len; i++)
               send(rand_sample(), (i == 0) && start_first, i == len - 1);
         end else begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
               send(rand_sample(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 7) == 0) drain_results();
      end
   endtask

   initial begin
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes at the reset window of three
      send(32'h7FFF_FFFF, 1'b1, 1'b0);
      send(32'h8000_0000, 1'b0, 1'b0);
      send(32'hFFFF_FFFF, 1'b0, 1'b0);
      send(32'h8000_0000, 1'b0, 1'b0);
      send(32'h0000_0001, 1'b0, 1'b1);
      // no start after a last: the window keeps running
      send(32'h5555_5555, 1'b0, 1'b0);
      // two-sample sequence, too short for a result
      send(32'hAAAA_AAAA, 1'b1, 1'b0);
      send(32'h1234_5678, 1'b0, 1'b1);
      send(32'h0000_0000, 1'b1, 1'b1);
      // zero length acts as one, applied mid-sequence
      load_window(5'd0);
      send(32'h8000_0000, 1'b0, 1'b0);
      send(32'hFFFF_FFFF, 1'b0, 1'b1);
      // oversize length acts as sixteen, over samples already held
      load_window(5'd17);
      for (int i = 0; i < 13; i++) send(rand_sample(), 1'b0, i == 12);

      while (samples_sent < 700) run_phase();
      req_tvalid <= 1'b0;

      waited = 0;
      while (board.pending() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, board.pending());
         board.errors += board.pending();
      end
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
